@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the zip bar code converter rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked at every clock edge outside reset
`define ZBC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every clock edge, reset included
`define ZBC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ZBC_ASSERT(label, prop, msg)
`define ZBC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/core/zbc_pkg.sv @@
// types, constants and code tables for the zip bar code converter
// no dependencies
`timescale 1ns / 1ps

package zbc_pkg;

	localparam int ZIP_W = 17;
	localparam int BAR_W = 27;
	localparam int GRP_W = 5;
	localparam int BODY_W = 25;

	localparam logic KIND_ENCODE = 1'b0;
	localparam logic KIND_DECODE = 1'b1;

	// x / 10 as (x * RECIP_10) >> RECIP_SHIFT, exact for every 17-bit x
	localparam logic [16:0] RECIP_10 = 17'd104858;
	localparam int RECIP_SHIFT = 20;

	localparam logic [ZIP_W-1:0] ZIP_MAX = 17'd99999;

	typedef struct packed {
		logic hit;
		logic [3:0] digit;
	} grp_hit_t;

	// one word in flight through the digit pipeline
	typedef struct packed {
		logic kind;
		logic [ZIP_W-1:0] val;
		logic [BODY_W-1:0] enc;
		logic [BODY_W-1:0] dec;
		logic [ZIP_W-1:0] zip;
		logic bad;
	} stage_t;

	function automatic logic [GRP_W-1:0] digit_pattern(input logic [3:0] d);
		logic [GRP_W-1:0] p;
		case (d)
			4'd0: p = 5'b11000;
			4'd1: p = 5'b00011;
			4'd2: p = 5'b00101;
			4'd3: p = 5'b00110;
			4'd4: p = 5'b01001;
			4'd5: p = 5'b01010;
			4'd6: p = 5'b01100;
			4'd7: p = 5'b10001;
			4'd8: p = 5'b10010;
			4'd9: p = 5'b10100;
			default: p = 5'b11000;
		endcase
		return p;
	endfunction

	function automatic grp_hit_t group_digit(input logic [GRP_W-1:0] g);
		grp_hit_t r;
		r.hit = 1'b1;
		unique case (g)
			5'b11000: r.digit = 4'd0;
			5'b00011: r.digit = 4'd1;
			5'b00101: r.digit = 4'd2;
			5'b00110: r.digit = 4'd3;
			5'b01001: r.digit = 4'd4;
			5'b01010: r.digit = 4'd5;
			5'b01100: r.digit = 4'd6;
			5'b10001: r.digit = 4'd7;
			5'b10010: r.digit = 4'd8;
			5'b10100: r.digit = 4'd9;
			default: begin
				r.hit = 1'b0;
				r.digit = 4'd0;
			end
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/zbc_if.sv @@
// request and response channels of the zip bar code converter
// depends on zbc_pkg for field widths
`timescale 1ns / 1ps

interface zbc_req_if import zbc_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic [ZIP_W-1:0] zip_value;
	logic [BAR_W-1:0] bar_bits;

	modport source (output valid, kind, zip_value, bar_bits, input ready);
	modport sink (input valid, kind, zip_value, bar_bits, output ready);
endinterface

interface zbc_rsp_if import zbc_pkg::*; ();
	logic valid;
	logic ready;
	logic [ZIP_W-1:0] zip_out;
	logic [BAR_W-1:0] bar_out;
	logic bad_group;

	modport source (output valid, zip_out, bar_out, bad_group, input ready);
	modport sink (input valid, zip_out, bar_out, bad_group, output ready);
endinterface

@@ rtl/core/zip_bar_code_converter.sv @@
// zip bar code converter top level: five-stage digit pipeline
// depends on zbc_pkg, zbc_if, zbc_step and assert_macros.svh
`timescale 1ns / 1ps
// usage
//   req carries one word per item: kind 0 encodes zip_value into 27 bars,
//   kind 1 decodes bar_bits into a zip value with a bad_group flag.
//   rsp returns one word per request, in order; unused fields are zero.
// timing
//   five register stages, one digit per stage, each holding one reciprocal
//   multiply for the divide by ten and a group lookup; the last stage drives
//   rsp directly, and each accepted word is registered by every stage in turn;
//   throughput one word per cycle while rsp.ready holds.
// reset
//   arst_n clears all stage valid bits; the pipeline is empty afterwards.
// stall
//   each stage holds its word while the one after it is full and stalled;
//   empty stages keep filling, so up to five words queue behind a stalled
//   rsp before req.ready drops. nothing is lost or repeated.

`include "assert_macros.svh"

module zip_bar_code_converter import zbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	zbc_req_if.sink req,
	zbc_rsp_if.source rsp
);

	stage_t init_d;
	stage_t nxt1, nxt2, nxt3, nxt4, nxt5;
	stage_t data_s1, data_s2, data_s3, data_s4, data_s5;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic rsp_enc, rsp_dec, enc_ok, pipe_full;

	always_comb begin
		init_d.kind = req.kind;
		init_d.val = req.zip_value;
		init_d.enc = '0;
		init_d.dec = req.bar_bits[BAR_W-2:1];
		init_d.zip = '0;
		init_d.bad = 1'b0;
	end

	zbc_step u_step1 (.cur(init_d), .nxt(nxt1));
	zbc_step u_step2 (.cur(data_s1), .nxt(nxt2));
	zbc_step u_step3 (.cur(data_s2), .nxt(nxt3));
	zbc_step u_step4 (.cur(data_s3), .nxt(nxt4));
	zbc_step u_step5 (.cur(data_s4), .nxt(nxt5));

	// a stage takes a word when empty or when its word moves on
	assign rdy5 = ~vld_s5 | rsp.ready;
	assign rdy4 = ~vld_s4 | rdy5;
	assign rdy3 = ~vld_s3 | rdy4;
	assign rdy2 = ~vld_s2 | rdy3;
	assign rdy1 = ~vld_s1 | rdy2;
	assign req.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= req.valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) data_s1 <= nxt1;
		if (rdy2 && vld_s1) data_s2 <= nxt2;
		if (rdy3 && vld_s2) data_s3 <= nxt3;
		if (rdy4 && vld_s3) data_s4 <= nxt4;
		if (rdy5 && vld_s4) data_s5 <= nxt5;
	end

	assign rsp.valid = vld_s5;
	assign rsp.zip_out = (data_s5.kind == KIND_DECODE) ? data_s5.zip : '0;
	assign rsp.bar_out = (data_s5.kind == KIND_ENCODE) ? {1'b1, data_s5.enc, 1'b1} : '0;
	assign rsp.bad_group = (data_s5.kind == KIND_DECODE) ? data_s5.bad : 1'b0;

	assign rsp_enc = rsp.valid && data_s5.kind == KIND_ENCODE;
	assign rsp_dec = rsp.valid && data_s5.kind == KIND_DECODE;
	assign enc_ok = rsp.bar_out[BAR_W-1] && rsp.bar_out[0] && $countones(rsp.bar_out) == 12;
	assign pipe_full = vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5;

	`ZBC_ASSERT(a_enc_framed, rsp_enc |-> enc_ok, "encoded bars lack frame or two-of-five shape")
	`ZBC_ASSERT(a_dec_range, rsp_dec |-> rsp.bar_out == '0 && rsp.zip_out <= ZIP_MAX, "decode out of range")
	`ZBC_ASSERT(a_mid_hold, vld_s3 && !rdy4 |=> vld_s3 && $stable(data_s3), "middle stage lost its word")
	`ZBC_ASSERT(a_ready_full, !req.ready |-> pipe_full, "input stalled with a free stage")
	`ZBC_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !rsp.valid, "response valid during reset")

endmodule

@@ rtl/core/zbc_step.sv @@
// one digit step: peels a decimal digit for encode, folds a bar group for decode
// depends on zbc_pkg
`timescale 1ns / 1ps

module zbc_step import zbc_pkg::*; (
	input stage_t cur,
	output stage_t nxt
);

	logic [2*ZIP_W-1:0] prod;
	logic [ZIP_W-1:0] quo;
	logic [ZIP_W-1:0] ten_quo;
	logic [ZIP_W-1:0] rem;
	logic [ZIP_W-1:0] zip_ten;
	grp_hit_t gh;

	always_comb begin
		prod = {{ZIP_W{1'b0}}, cur.val} * {{ZIP_W{1'b0}}, RECIP_10};
		quo = ZIP_W'(prod >> RECIP_SHIFT);
		ten_quo = (quo << 3) + (quo << 1);
		rem = cur.val - ten_quo;

		gh = group_digit(cur.dec[BODY_W-1 -: GRP_W]);
		zip_ten = (cur.zip << 3) + (cur.zip << 1) + {{(ZIP_W-4){1'b0}}, gh.digit};

		nxt.kind = cur.kind;
		nxt.val = quo;
		// least significant digit enters at the top and drifts toward bit 0
		nxt.enc = {digit_pattern(rem[3:0]), cur.enc[BODY_W-1:GRP_W]};
		nxt.dec = cur.dec << GRP_W;
		// an unknown group leaves the value unshifted
		nxt.zip = gh.hit ? zip_ten : cur.zip;
		nxt.bad = cur.bad | ~gh.hit;
	end

endmodule
